// ----- sv/rcc_pkg.sv -----
// ----------------------------------------------------------------------------
// rcc_pkg
// Shared types, constants and helpers of the receiver channel conditioner.
// ----------------------------------------------------------------------------
`default_nettype none

package rcc_pkg;

  localparam int unsigned ChannelsDefault = 8;

  localparam int unsigned ChanW   = 3;
  localparam int unsigned PulseW  = 16;
  localparam int unsigned RangeW  = 12;
  localparam int unsigned MaskW   = 8;
  localparam int unsigned GainW   = 16;
  localparam int unsigned CmdW    = 10;
  localparam int unsigned FiltW   = 18;
  localparam int unsigned CountW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;

  // scaling divider: |num| < 2^23, divisor is max - min
  localparam int unsigned DvdW = 23;

  localparam logic [RangeW-1:0] PulseMinReset = 12'd1100;
  localparam logic [RangeW-1:0] PulseMaxReset = 12'd1900;
  localparam logic [MaskW-1:0]  DirMaskReset  = 8'd0;
  localparam logic [MaskW-1:0]  StopMaskReset = 8'd196;
  localparam logic [GainW-1:0]  GainReset     = 16'd8231;

  localparam logic [PulseW-1:0] PulseLow    = 16'd500;
  localparam logic [PulseW-1:0] PulseHigh   = 16'd2500;
  localparam logic [PulseW-1:0] LinkCenter  = 16'd1500;
  localparam logic [PulseW-1:0] LinkLow     = 16'd1000;
  localparam logic [PulseW-1:0] LinkHigh    = 16'd2000;
  localparam logic [CountW:0]   GoodLimit   = 9'd200;
  localparam logic signed [CmdW-1:0]  CmdMax = 10'sd500;
  localparam logic signed [CmdW-1:0]  CmdMin = -10'sd500;
  localparam logic signed [FiltW-1:0] FiltMax = 18'sd131071;
  localparam logic signed [FiltW-1:0] FiltMin = -18'sd131071;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPulseMin = 3'd0,
    CfgPulseMax = 3'd1,
    CfgDirMask  = 3'd2,
    CfgStopMask = 3'd3,
    CfgGain     = 3'd4
  } cfg_idx_e;

  // channel modulo channel count, by repeated subtraction
  function automatic logic [4:0] chan_mod(logic [ChanW-1:0] ch, int unsigned n);
    logic [4:0] r;
    r = {2'b00, ch};
    for (int i = 0; i < 8; i++) begin
      if (32'(r) >= n) begin
        r = r - 5'(n);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/rcc_divider.sv -----
// ----------------------------------------------------------------------------
// rcc_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rcc_divider
  import rcc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DvdW-1:0]   dividend_i,
  input  wire logic [RangeW-1:0] divisor_i,
  output logic                   done_o,
  output logic [DvdW-1:0]        quotient_o
);

  localparam int unsigned CntW = $clog2(DvdW);

  logic              busy_q;
  logic              done_q;
  logic [CntW-1:0]   cnt_q;
  logic [DvdW-1:0]   dvd_q;
  logic [RangeW-1:0] rem_q;
  logic [RangeW-1:0] div_q;

  logic [RangeW:0]   trial;
  logic              qbit;
  logic [RangeW-1:0] rem_next;

  always_comb begin
    trial = {rem_q, dvd_q[DvdW-1]};
    qbit  = trial >= {1'b0, div_q};
    if (qbit) begin
      rem_next = RangeW'(trial - {1'b0, div_q});
    end else begin
      rem_next = trial[RangeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DvdW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DvdW-2:0], qbit};
      rem_q <= rem_next;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < div_q) else $error("partial remainder not below divisor");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_q) else $error("divider done while still iterating");

endmodule

`default_nettype wire

// ----- sv/rcc_filter.sv -----
// ----------------------------------------------------------------------------
// rcc_filter
// One-pole low-pass update in signed Q.8: multiply stage, then shift and add.
// ----------------------------------------------------------------------------
`default_nettype none

module rcc_filter
  import rcc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic signed [CmdW-1:0]  cmd_i,
  input  wire logic signed [FiltW-1:0] filt_i,
  input  wire logic [GainW-1:0]        gain_i,
  output logic                        done_o,
  output logic signed [FiltW-1:0]     filt_o
);

  localparam int unsigned DiffW = FiltW + 2;
  localparam int unsigned ProdW = DiffW + GainW + 1;

  logic signed [DiffW-1:0] diff;
  logic                    minor_step;
  logic signed [ProdW-1:0] prod;

  logic                    mul_vld_q;
  logic                    done_q;
  logic signed [ProdW-1:0] prod_q;
  logic                    minor_step_q;
  logic signed [FiltW-1:0] fold_q;
  logic signed [FiltW-1:0] fnew_q;

  logic signed [ProdW-1:0] step;
  logic signed [ProdW:0]   sum;
  logic signed [FiltW-1:0] sat;

  always_comb begin
    diff       = DiffW'($signed({cmd_i, 8'd0})) - DiffW'(filt_i);
    minor_step = (diff > -20'sd25600) && (diff < 20'sd25600);
    prod       = $signed({1'b0, gain_i}) * diff;
  end

  always_comb begin
    step = minor_step_q ? (prod_q >>> 16) : (prod_q >>> 17);
    sum  = (ProdW+1)'(fold_q) + (ProdW+1)'(step);
    if (sum > (ProdW+1)'(FiltMax)) begin
      sat = FiltMax;
    end else if (sum < (ProdW+1)'(FiltMin)) begin
      sat = FiltMin;
    end else begin
      sat = sum[FiltW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      mul_vld_q <= start_i;
      done_q    <= mul_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q       <= prod;
      minor_step_q <= minor_step;
      fold_q       <= filt_i;
    end
    if (mul_vld_q) begin
      fnew_q <= sat;
    end
  end

  assign done_o = done_q;
  assign filt_o = fnew_q;

endmodule

`default_nettype wire

// ----- sv/rc_channel_conditioner.sv -----
// ----------------------------------------------------------------------------
// rc_channel_conditioner
// Per-channel receiver pulse check, command scaling and low-pass filter.
// ----------------------------------------------------------------------------
// One item at a time. A scaled receiver pulse passes from accept to result
// through an evaluation state, the bit-serial divider for
// ((p-min)*1000 - (max-min)*500)/(max-min) (23 quotient bits), a filter
// start, the filter's multiply and add stages and the output register load.
// Fallback, range-fault and error paths skip the divider.
// The input is ready again once the result is loaded; a result left
// waiting in the output register stalls only the next item's done state.
`default_nettype none

module rc_channel_conditioner
  import rcc_pkg::*;
#(
  parameter int unsigned CHANNELS = ChannelsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // channel, pulse_width, radio_valid, datalink_valid, datalink_pulse
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // out_channel, command, filtered, channel_error, range_fault
  output logic [OutDataW-1:0]      m_axis_tdata_o,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgW-1:0]     cfg_data_i
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [2:0] {
    StIdle,
    StEval,
    StDiv,
    StFilt,
    StFiltWait,
    StDone
  } state_e;

  state_e state_q;

  logic [RangeW-1:0] pulse_min_q;
  logic [RangeW-1:0] pulse_max_q;
  logic [MaskW-1:0]  dir_mask_q;
  logic [MaskW-1:0]  stop_mask_q;
  logic [GainW-1:0]  gain_q;

  logic                   err_q  [CHANNELS];
  logic [CountW-1:0]      cnt_q  [CHANNELS];
  logic signed [CmdW-1:0] cmds_q [CHANNELS];
  logic signed [FiltW-1:0] filt_q [CHANNELS];

  logic [ChanW-1:0]  ch_q;
  logic [IdxW-1:0]   k_q;
  logic [PulseW-1:0] pw_q;
  logic              radio_q;
  logic              link_q;
  logic [PulseW-1:0] dl_q;

  logic                   neg_q;
  logic signed [CmdW-1:0] cmd_q;
  logic                   err_out_q;
  logic                   fault_q;

  logic                    out_vld_q;
  logic [ChanW-1:0]        och_q;
  logic signed [CmdW-1:0]  ocmd_q;
  logic signed [FiltW-1:0] ofilt_q;
  logic                    oerr_q;
  logic                    ofault_q;

  logic                   s_accept;
  logic                   out_free;
  logic                   bad_pulse;
  logic [CountW:0]        cnt_inc;
  logic                   err_new;
  logic [CountW-1:0]      cnt_new;
  logic                   scaled;
  logic                   fault;
  logic [RangeW-1:0]      span;
  logic [13:0]            offs;
  logic [DvdW:0]          num;
  logic [DvdW-1:0]        num_mag;
  logic [PulseW-1:0]      dl_off;
  logic signed [CmdW-1:0] fb_cmd;
  logic [8:0]             lim_mag;
  logic signed [CmdW-1:0] div_cmd;

  logic                    div_start;
  logic                    div_done;
  logic [DvdW-1:0]         div_q;
  logic                    filt_start;
  logic                    filt_done;
  logic signed [FiltW-1:0] filt_new;

  assign s_accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !out_vld_q || m_axis_tready_i;
  assign fault     = pulse_min_q >= pulse_max_q;

  always_comb begin
    bad_pulse = (pw_q > PulseHigh) || (pw_q < PulseLow);
    cnt_inc   = {1'b0, cnt_q[k_q]} + 1'b1;
    err_new   = err_q[k_q];
    cnt_new   = cnt_q[k_q];
    if (radio_q) begin
      if (bad_pulse) begin
        err_new = 1'b1;
        cnt_new = '0;
      end else if (cnt_inc > GoodLimit) begin
        err_new = 1'b0;
        cnt_new = GoodLimit[CountW-1:0];
      end else begin
        cnt_new = cnt_inc[CountW-1:0];
      end
    end
    scaled = radio_q && !err_new;
  end

  always_comb begin
    span    = pulse_max_q - pulse_min_q;
    offs    = 14'(pw_q[RangeW-1:0]) - 14'(pulse_min_q);
    num     = {{(DvdW-13){offs[13]}}, offs} * 24'd1000 - 24'(span) * 24'd500;
    num_mag = num[DvdW] ? DvdW'(-num) : num[DvdW-1:0];
  end

  always_comb begin
    dl_off = dl_q - LinkCenter;
    if (!link_q) begin
      fb_cmd = stop_mask_q[ch_q] ? CmdMin : '0;
    end else if (dl_q > LinkHigh) begin
      fb_cmd = CmdMax;
    end else if (dl_q < LinkLow) begin
      fb_cmd = CmdMin;
    end else begin
      fb_cmd = dl_off[CmdW-1:0];
    end
  end

  always_comb begin
    lim_mag = (div_q > DvdW'(500)) ? 9'd500 : div_q[8:0];
    div_cmd = neg_q ? -$signed({1'b0, lim_mag}) : $signed({1'b0, lim_mag});
  end

  assign div_start  = (state_q == StEval) && scaled && !fault;
  assign filt_start = (state_q == StFilt);

  rcc_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_mag),
    .divisor_i  (span),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  rcc_filter u_filt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (filt_start),
    .cmd_i   (cmd_q),
    .filt_i  (filt_q[k_q]),
    .gain_i  (gain_q),
    .done_o  (filt_done),
    .filt_o  (filt_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_min_q <= PulseMinReset;
      pulse_max_q <= PulseMaxReset;
      dir_mask_q  <= DirMaskReset;
      stop_mask_q <= StopMaskReset;
      gain_q      <= GainReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPulseMin: pulse_min_q <= cfg_data_i[RangeW-1:0];
        CfgPulseMax: pulse_max_q <= cfg_data_i[RangeW-1:0];
        CfgDirMask:  dir_mask_q  <= cfg_data_i[MaskW-1:0];
        CfgStopMask: stop_mask_q <= cfg_data_i[MaskW-1:0];
        CfgGain:     gain_q      <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StIdle;
      s_axis_tready_o <= 1'b1;
      out_vld_q       <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        err_q[i]  <= 1'b0;
        cnt_q[i]  <= '0;
        cmds_q[i] <= '0;
        filt_q[i] <= '0;
      end
    end else begin
      // the done state reloads the output register itself
      if (out_vld_q && m_axis_tready_i && (state_q != StDone)) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (s_accept) begin
            s_axis_tready_o <= 1'b0;
            state_q         <= StEval;
          end
        end
        StEval: begin
          err_q[k_q] <= err_new;
          cnt_q[k_q] <= cnt_new;
          if (scaled && !fault) begin
            state_q <= StDiv;
          end else begin
            state_q <= StFilt;
          end
        end
        StDiv: begin
          if (div_done) begin
            state_q <= StFilt;
          end
        end
        StFilt: begin
          state_q <= StFiltWait;
        end
        StFiltWait: begin
          if (filt_done) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (out_free) begin
            out_vld_q       <= 1'b1;
            cmds_q[k_q]     <= cmd_q;
            filt_q[k_q]     <= filt_new;
            s_axis_tready_o <= 1'b1;
            state_q         <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      ch_q    <= s_axis_tdata_i[2:0];
      k_q     <= IdxW'(chan_mod(s_axis_tdata_i[2:0], CHANNELS));
      pw_q    <= s_axis_tdata_i[18:3];
      radio_q <= s_axis_tdata_i[19];
      link_q  <= s_axis_tdata_i[20];
      dl_q    <= s_axis_tdata_i[36:21];
    end
    if (state_q == StEval) begin
      err_out_q <= err_new;
      fault_q   <= fault;
      neg_q     <= num[DvdW] ^ dir_mask_q[ch_q];
      if (!scaled) begin
        cmd_q <= fb_cmd;
      end else begin
        cmd_q <= cmds_q[k_q];
      end
    end
    if (state_q == StDiv && div_done) begin
      cmd_q <= div_cmd;
    end
    if (state_q == StDone && out_free) begin
      och_q    <= ch_q;
      ocmd_q   <= cmd_q;
      ofilt_q  <= filt_new;
      oerr_q   <= err_out_q;
      ofault_q <= fault_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {7'd0, ofault_q, oerr_q, ofilt_q, ocmd_q, och_q};

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> !s_axis_tready_o) else $error("input taken while an item is in work");
  a_cmd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (ocmd_q <= CmdMax) && (ocmd_q >= CmdMin))
    else $error("command out of range");
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEval) |-> (cnt_q[k_q] <= GoodLimit[CountW-1:0]))
    else $error("good-pulse count above limit");
  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == StDiv)) else $error("divider result outside divide phase");

endmodule

`default_nettype wire

// ----- sim/tb_rc_channel_conditioner.sv -----
// ----------------------------------------------------------------------------
// tb_rc_channel_conditioner
// Self-checking bench for the receiver channel conditioner. An in-bench model
// tracks per-channel error flags, good-pulse counts, commands and filter
// values, predicts every result and checks it field by field. The stimulus is
// a short directed set followed by per-channel recovery runs under several
// range, mask and gain settings, with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_rc_channel_conditioner;
  timeunit 1ns;
  timeprecision 1ps;

  import rcc_pkg::*;

  localparam int unsigned CHANNELS   = ChannelsDefault;
  localparam int unsigned IdleLimit  = 5000;
  localparam int unsigned MaxReports = 30;

  localparam longint LoPulse    = PulseLow;
  localparam longint HiPulse    = PulseHigh;
  localparam longint GoodMax    = GoodLimit;
  localparam longint LinkMid    = LinkCenter;
  localparam longint CmdLim     = CmdMax;
  localparam longint FiltLim    = FiltMax;
  localparam longint StopLow    = LinkLow;
  localparam longint ScaleSpan  = 1000;
  localparam longint ScaleHalf  = 500;
  localparam longint Q8One      = 256;
  localparam longint StepThresh = 100 * Q8One;
  localparam longint GainOne    = 65536;

  typedef struct packed {
    logic [PulseW-1:0] dl_pulse;
    logic              dl_valid;
    logic              radio_valid;
    logic [PulseW-1:0] pulse;
    logic [ChanW-1:0]  chan;
  } sample_t;

  typedef struct packed {
    logic              range_fault;
    logic              chan_error;
    logic [FiltW-1:0]  filtered;
    logic [CmdW-1:0]   command;
    logic [ChanW-1:0]  chan;
  } result_t;

  typedef enum logic [1:0] {StallNone, StallCoin, StallHeavy, StallComb} stall_e;

  class chan_scoreboard;
    longint pulse_min;
    longint pulse_max;
    bit [MaskW-1:0] dir_mask;
    bit [MaskW-1:0] stop_mask;
    longint gain;
    bit err_flag[CHANNELS];
    longint good_cnt[CHANNELS];
    longint cmd_hist[CHANNELS];
    longint filt_q8[CHANNELS];
    result_t expected_q[$];
    int errors;

    function new();
      pulse_min = PulseMinReset;
      pulse_max = PulseMaxReset;
      dir_mask  = DirMaskReset;
      stop_mask = StopMaskReset;
      gain      = GainReset;
      errors    = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgW-1:0] v);
      case (idx)
        CfgPulseMin: pulse_min = v[RangeW-1:0];
        CfgPulseMax: pulse_max = v[RangeW-1:0];
        CfgDirMask:  dir_mask  = v[MaskW-1:0];
        CfgStopMask: stop_mask = v[MaskW-1:0];
        CfgGain:     gain      = v[GainW-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp_cmd(longint v);
      if (v > CmdLim) return CmdLim;
      if (v < -CmdLim) return -CmdLim;
      return v;
    endfunction

    function void note_input(sample_t s);
      int unsigned k;
      longint pw, span, cmd, diff, mag, dv, prod, stepv, f;
      bit fault, scaled;
      result_t r;
      k      = s.chan % CHANNELS;
      pw     = s.pulse;
      fault  = pulse_min >= pulse_max;
      cmd    = cmd_hist[k];
      scaled = 1'b0;
      if (s.radio_valid) begin
        if (pw > HiPulse || pw < LoPulse) begin
          err_flag[k] = 1'b1;
          good_cnt[k] = 0;
        end else if (good_cnt[k] >= GoodMax) begin
          good_cnt[k] = GoodMax;
          err_flag[k] = 1'b0;
        end else begin
          good_cnt[k]++;
        end
        if (!err_flag[k]) begin
          scaled = 1'b1;
          if (!fault) begin
            span = pulse_max - pulse_min;
            cmd  = clamp_cmd(((pw - pulse_min) * ScaleSpan - ScaleHalf * span) / span);
            if (dir_mask[s.chan]) cmd = -cmd;
          end
        end
      end
      if (!scaled) begin
        if (s.dl_valid) cmd = clamp_cmd(longint'(s.dl_pulse) - LinkMid);
        else cmd = stop_mask[s.chan] ? StopLow - LinkMid : 0;
      end
      cmd_hist[k] = cmd;

      // one-pole filter in Q.8, half gain on large steps, floor rounding
      f     = filt_q8[k];
      diff  = cmd * Q8One - f;
      mag   = (diff < 0) ? -diff : diff;
      dv    = (mag < StepThresh) ? GainOne : 2 * GainOne;
      prod  = gain * diff;
      stepv = prod / dv;
      if (prod < 0 && stepv * dv != prod) stepv = stepv - 1;
      f = f + stepv;
      if (f > FiltLim) f = FiltLim;
      if (f < -FiltLim) f = -FiltLim;
      filt_q8[k] = f;

      r.chan        = s.chan;
      r.command     = CmdW'(cmd);
      r.filtered    = FiltW'(f);
      r.chan_error  = err_flag[k];
      r.range_fault = fault;
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MaxReports) $display("%0t ns mismatch: %s", $realtime, msg);
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("ch %0d item with nothing pending", got.chan));
        return;
      end
      want = expected_q.pop_front();
      if (got.chan != want.chan)
        report($sformatf("channel %0d, want %0d", got.chan, want.chan));
      if (got.command != want.command)
        report($sformatf("ch %0d command %0d, want %0d", want.chan,
                         $signed(got.command), $signed(want.command)));
      if (got.filtered != want.filtered)
        report($sformatf("ch %0d filtered %0d, want %0d", want.chan,
                         $signed(got.filtered), $signed(want.filtered)));
      if (got.chan_error != want.chan_error)
        report($sformatf("ch %0d channel_error %0b, want %0b", want.chan,
                         got.chan_error, want.chan_error));
      if (got.range_fault != want.range_fault)
        report($sformatf("ch %0d range_fault %0b, want %0b", want.chan,
                         got.range_fault, want.range_fault));
    endtask
  endclass

  logic                clk;
  logic                rst_n      = 1'b0;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx    = '0;
  logic [CfgW-1:0]     cfg_data   = '0;

  chan_scoreboard sb = new();
  int     burst_left = 0;
  stall_e stall_mode = StallNone;
  logic [15:0] stall_cnt = '0;

  rc_channel_conditioner #(
    .CHANNELS(CHANNELS)
  ) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tdata_i (in_tdata),
    .s_axis_tvalid_i(in_tvalid),
    .s_axis_tready_o(in_tready),
    .m_axis_tdata_o (out_tdata),
    .m_axis_tvalid_o(out_tvalid),
    .m_axis_tready_i(out_tready),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 16'd1;
    if (stall_cnt[6:0] == 7'd0) stall_mode <= stall_e'($urandom_range(0, 3));
    case (stall_mode)
      StallNone:  out_tready <= 1'b1;
      StallCoin:  out_tready <= $urandom_range(0, 1);
      StallHeavy: out_tready <= ($urandom_range(0, 7) == 0);
      default:    out_tready <= (stall_cnt[2:0] != 3'd0);
    endcase
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_result(result_t'(out_tdata[$bits(result_t)-1:0]));
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic sample_t mk(int ch, int pw, bit rv, bit lv, int dl);
    sample_t s;
    s.chan        = ch[ChanW-1:0];
    s.pulse       = pw[PulseW-1:0];
    s.radio_valid = rv;
    s.dl_valid    = lv;
    s.dl_pulse    = dl[PulseW-1:0];
    return s;
  endfunction

  function automatic int good_pulse();
    int v;
    case ($urandom_range(0, 5))
      0:       v = LoPulse;
      1:       v = HiPulse;
      2:       v = int'(sb.pulse_min) + int'($urandom_range(0, 8)) - 4;
      3:       v = int'(sb.pulse_max) + int'($urandom_range(0, 8)) - 4;
      default: v = $urandom_range(LoPulse, HiPulse);
    endcase
    if (v < LoPulse) v = LoPulse;
    if (v > HiPulse) v = HiPulse;
    return v;
  endfunction

  function automatic int bad_pulse();
    return $urandom_range(0, 1) ? $urandom_range(0, LoPulse - 1)
                                : $urandom_range(HiPulse + 1, 65535);
  endfunction

  function automatic int link_value();
    return $urandom_range(0, 3) ? $urandom_range(900, 2100) : $urandom_range(0, 65535);
  endfunction

  function automatic sample_t noise();
    int pw;
    case ($urandom_range(0, 2))
      0:       pw = $urandom_range(0, 65535);
      1:       pw = bad_pulse();
      default: pw = good_pulse();
    endcase
    return mk($urandom_range(0, 7), pw, $urandom_range(0, 1), $urandom_range(0, 1),
              link_value());
  endfunction

  task automatic push(sample_t s);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 30);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_tdata  <= InDataW'(s);
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(s);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic program_regs(int mn, int mx, int dir, int stp, int g);
    write_reg(CfgPulseMin, CfgW'(mn));
    write_reg(CfgPulseMax, CfgW'(mx));
    write_reg(CfgDirMask, CfgW'(dir));
    write_reg(CfgStopMask, CfgW'(stp));
    write_reg(CfgGain, CfgW'(g));
    cfg_we <= 1'b0;
  endtask

  // knock one channel into error, then feed it good pulses until it recovers
  task automatic run_episode();
    int focus, sent, target;
    sample_t s;
    repeat ($urandom_range(15, 30)) push(noise());
    focus = $urandom_range(0, CHANNELS - 1);
    push(mk(focus, bad_pulse(), 1'b1, $urandom_range(0, 1), link_value()));
    sent   = 0;
    target = GoodMax + 1 + $urandom_range(0, 6);
    while (sent < target) begin
      if ($urandom_range(0, 7) == 0) begin
        s = noise();
        if (s.chan == focus) s.chan = ChanW'(focus ^ $urandom_range(1, 7));
        push(s);
      end else begin
        s = mk(focus, good_pulse(), ($urandom_range(0, 15) != 0), $urandom_range(0, 1),
               link_value());
        push(s);
        if (s.radio_valid) sent++;
      end
    end
  endtask

  initial begin
    int mn;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default registers: range ends, pulse limits, link and stop fallbacks
    push(mk(0, 1100, 1, 0, 0));
    push(mk(1, 1900, 1, 0, 0));
    push(mk(2, 1500, 1, 1, 65535));
    push(mk(3, 500, 1, 0, 0));
    push(mk(4, 2500, 1, 0, 0));
    push(mk(0, 1234, 1, 0, 0));
    push(mk(1, 1567, 1, 1, 0));
    push(mk(5, 499, 1, 1, 1750));
    push(mk(6, 2501, 1, 0, 0));
    push(mk(7, 0, 1, 0, 0));
    push(mk(5, 65535, 1, 1, 65535));
    push(mk(5, 32768, 1, 1, 0));
    push(mk(2, 65535, 0, 0, 0));
    push(mk(2, 0, 0, 1, 2000));
    push(mk(2, 1500, 0, 1, 1000));
    push(mk(1, 1500, 0, 1, 1500));
    push(mk(3, 21845, 0, 1, 43690));
    push(mk(3, 43690, 0, 1, 21845));
    push(mk(4, 2000, 1, 1, 2001));
    push(mk(7, 1700, 1, 1, 999));
    run_episode();
    settle();

    program_regs(0, 4095, 8'hFF, 8'h00, 16'hFFFF);
    run_episode();
    settle();

    program_regs(4095, 0, $urandom_range(0, 255), 8'hFF, 0);
    run_episode();
    settle();

    mn = $urandom_range(500, 2400);
    program_regs(mn, mn + $urandom_range(1, 3), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 65535));
    run_episode();
    settle();

    mn = $urandom_range(0, 4095);
    program_regs(mn, mn, $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 65535));
    run_episode();
    settle();
    repeat (40) @(posedge clk);

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
